/* rtl/ole_pkg.sv */
`timescale 1ns / 1ps

package ole_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 7;
    localparam int DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOCATE = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_ROTATE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [POS_W-1:0]  pidx;
    } cell_ctrl_t;

endpackage

/* rtl/ordered_list_engine.sv */
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed 32-bit entries held in a ring of cells.
// Input channel: in_valid/in_stall carry one word (opcode, position, value).
// Output channel: out_valid/out_stall carry one result word (status,
// found_position, removed_value, entry_count) for every input word.
// A word is taken on a rising edge with valid high and stall low.
// Path to the output register:
//   insert, clear, a rejected delete, locate on an empty list: registered in the cycle after the word is taken.
//   accepted delete, locate on a non-empty list: in S_ROT the ring
//   rotates one full turn past cell 0, where the entry is read or compared,
//   then S_FIN closes the gap of a delete in a parallel shift.
// One word is in flight at a time; in_stall is high while a delete or locate
// is in progress or while a finished result waits under out_stall.
// A result waits in the output register, unchanged, while out_stall is high.
// Reset clears the count, the control state and out_valid; entry contents
// are not cleared and are never read before they are written.
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               opcode,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [POS_W-1:0]         found_position,
    output logic signed [DATA_W-1:0] removed_value,
    output logic [POS_W-1:0]         entry_count
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW + 1 : POS_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_FIN
    } state_t;

    state_t            state_reg,   state_next;
    logic [IW-1:0]     rot_cnt_reg, rot_cnt_next;
    opcode_t           op_reg,      op_next;
    logic [POS_W-1:0]  pidx_reg,    pidx_next;
    logic [DATA_W-1:0] key_reg,     key_next;
    logic              hit_reg,     hit_next;
    logic [POS_W-1:0]  found_reg,   found_next;
    logic [DATA_W-1:0] taken_reg,   taken_next;
    logic [CW-1:0]     count_reg,   count_next;

    logic              out_valid_reg,      out_valid_next;
    status_t           status_reg,         status_next;
    logic [POS_W-1:0]  found_position_reg, found_position_next;
    logic [DATA_W-1:0] removed_value_reg,  removed_value_next;
    logic [POS_W-1:0]  entry_count_reg,    entry_count_next;

    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] head_data;

    logic              out_free;
    logic              produce;
    logic [CMPW-1:0]   pos_ext;
    logic [CMPW-1:0]   cnt_ext;
    logic [CMPW-1:0]   rot_ext;
    logic [POS_W-1:0]  pos_idx;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign head_data = cell_data[0];
    assign pos_ext   = CMPW'(position);
    assign cnt_ext   = CMPW'(count_reg);
    assign rot_ext   = CMPW'(rot_cnt_reg);
    assign pos_idx   = position - POS_W'(1);

    always_comb
    begin
        state_next          = state_reg;
        rot_cnt_next        = rot_cnt_reg;
        op_next             = op_reg;
        pidx_next           = pidx_reg;
        key_next            = key_reg;
        hit_next            = hit_reg;
        found_next          = found_reg;
        taken_next          = taken_reg;
        count_next          = count_reg;
        out_valid_next      = out_valid_reg && out_stall;
        status_next         = status_reg;
        found_position_next = found_position_reg;
        removed_value_next  = removed_value_reg;
        entry_count_next    = entry_count_reg;
        produce             = 1'b0;
        ctrl.cmd            = CMD_HOLD;
        ctrl.pidx           = pidx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && out_free)
                begin
                    found_position_next = '0;
                    removed_value_next  = '0;
                    status_next         = ST_OK;
                    unique case (opcode_t'(opcode))
                        OP_INSERT:
                        begin
                            produce = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (position == '0 || pos_ext > cnt_ext + CMPW'(1))
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                ctrl.cmd   = CMD_INSERT;
                                ctrl.pidx  = pos_idx;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (position == '0 || pos_ext > cnt_ext)
                            begin
                                produce     = 1'b1;
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                op_next      = OP_DELETE;
                                pidx_next    = pos_idx;
                                rot_cnt_next = '0;
                                state_next   = S_ROT;
                            end
                        end
                        OP_LOCATE:
                        begin
                            if (count_reg == '0)
                            begin
                                produce     = 1'b1;
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                op_next      = OP_LOCATE;
                                key_next     = value;
                                hit_next     = 1'b0;
                                found_next   = '0;
                                rot_cnt_next = '0;
                                state_next   = S_ROT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            produce    = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end
            S_ROT:
            begin
                ctrl.cmd = CMD_ROTATE;
                if (op_reg == OP_DELETE)
                begin
                    if (rot_ext == CMPW'(pidx_reg))
                    begin
                        taken_next = head_data;
                    end
                end
                else if (!hit_reg && rot_ext < cnt_ext && head_data == key_reg)
                begin
                    hit_next   = 1'b1;
                    found_next = POS_W'({1'b0, rot_cnt_reg} + (IW + 1)'(1));
                end
                rot_cnt_next = rot_cnt_reg + IW'(1);
                if (rot_cnt_reg == IW'(DEPTH - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                produce    = 1'b1;
                state_next = S_IDLE;
                if (op_reg == OP_DELETE)
                begin
                    ctrl.cmd            = CMD_DELETE;
                    ctrl.pidx           = pidx_reg;
                    count_next          = count_reg - CW'(1);
                    status_next         = ST_OK;
                    found_position_next = '0;
                    removed_value_next  = taken_reg;
                end
                else
                begin
                    status_next         = hit_reg ? ST_OK : ST_NOT_FOUND;
                    found_position_next = found_reg;
                    removed_value_next  = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (produce)
        begin
            out_valid_next   = 1'b1;
            entry_count_next = POS_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rot_cnt_reg   <= '0;
            op_reg        <= OP_INSERT;
            count_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rot_cnt_reg   <= rot_cnt_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg           <= pidx_next;
        key_reg            <= key_next;
        found_reg          <= found_next;
        taken_reg          <= taken_next;
        status_reg         <= status_next;
        found_position_reg <= found_position_next;
        removed_value_reg  <= removed_value_next;
        entry_count_reg    <= entry_count_next;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int L = (i + DEPTH - 1) % DEPTH;
        localparam int R = (i + 1) % DEPTH;

        ole_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .load_data  (value),
            .left_data  (cell_data[L]),
            .right_data (cell_data[R]),
            .data       (cell_data[i])
        );
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = found_position_reg;
    assign removed_value  = removed_value_reg;
    assign entry_count    = entry_count_reg;

endmodule

/* rtl/ole_cell.sv */
`timescale 1ns / 1ps

module ole_cell
    import ole_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] load_data,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data
);

    localparam int IDX_W = ($clog2(DEPTH) > POS_W) ? $clog2(DEPTH) + 1 : POS_W + 1;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [IDX_W-1:0]  my_idx;
    logic [IDX_W-1:0]  sel_idx;

    assign my_idx  = IDX_W'(INDEX);
    assign sel_idx = IDX_W'(ctrl.pidx);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.cmd)
            CMD_HOLD:
            begin
                data_next = data_reg;
            end
            CMD_INSERT:
            begin
                if (my_idx > sel_idx)
                begin
                    data_next = left_data;
                end
                else if (my_idx == sel_idx)
                begin
                    data_next = load_data;
                end
            end
            CMD_DELETE:
            begin
                if (my_idx >= sel_idx)
                begin
                    data_next = right_data;
                end
            end
            CMD_ROTATE:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* tb/ordered_list_engine_tb.sv */
`timescale 1ns / 1ps

module ordered_list_engine_tb;
    import ole_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LONG  = 400;

    typedef struct {
        opcode_t            op;
        status_t            status;
        logic [POS_W-1:0]   found;
        logic signed [31:0] removed;
        logic [POS_W-1:0]   count;
    } list_result_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    opcode_t                  opcode = OP_INSERT;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic [POS_W-1:0]         found_position;
    logic signed [DATA_W-1:0] removed_value;
    logic [POS_W-1:0]         entry_count;

    logic signed [31:0] shadow_list [DEPTH];
    int                 shadow_count = 0;
    list_result_t       pending_results [$];

    int   errors      = 0;
    int   result_num  = 0;
    int   idle_cycles = 0;
    int   hold_cycles = 0;
    int   burst_left  = 4;
    logic gaps_on     = 1'b1;

    ordered_list_engine #(.DEPTH(DEPTH)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .removed_value  (removed_value),
        .entry_count    (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Shadow list update for one accepted word; returns the expected result.
    function automatic list_result_t list_apply(opcode_t op, logic [POS_W-1:0] pos,
                                                logic signed [31:0] val);
        list_result_t r;
        int p;
        int k;
        p         = int'(pos);
        r.op      = op;
        r.status  = ST_OK;
        r.found   = '0;
        r.removed = '0;
        case (op)
            OP_INSERT:
            begin
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else if (p == 0 || p > shadow_count + 1)
                    r.status = ST_BAD_POS;
                else
                begin
                    for (k = shadow_count; k >= p; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[p-1] = val;
                    shadow_count++;
                end
            end
            OP_DELETE:
            begin
                if (p == 0 || p > shadow_count)
                    r.status = ST_BAD_POS;
                else
                begin
                    r.removed = shadow_list[p-1];
                    for (k = p; k < shadow_count; k++)
                        shadow_list[k-1] = shadow_list[k];
                    shadow_count--;
                end
            end
            OP_LOCATE:
            begin
                r.status = ST_NOT_FOUND;
                for (k = 0; k < shadow_count && r.status == ST_NOT_FOUND; k++)
                begin
                    if (shadow_list[k] === val)
                    begin
                        r.status = ST_OK;
                        r.found  = POS_W'(k + 1);
                    end
                end
            end
            default:
                shadow_count = 0;
        endcase
        r.count = POS_W'(shadow_count);
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3, 0))
            0: return $urandom_range(15, 0) - 8;
            1:
            begin
                case ($urandom_range(3, 0))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("MISMATCH result %0d %s: got %0h expected %0h", result_num, what, got, want);
    endtask

    // Send one word; waits for the edge that takes it, then may drop in_valid for a random gap.
    task automatic send_word(opcode_t op, logic [POS_W-1:0] pos, logic signed [31:0] val);
        list_result_t r;
        int gap;
        in_valid <= 1'b1;
        opcode   <= op;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = list_apply(op, pos, val);
        pending_results.push_back(r);
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(8, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(30, 1);
        end
        else if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_list();
        send_word(OP_DELETE, 7'd1, 32'sd0);
        send_word(OP_DELETE, 7'd0, 32'sd0);
        send_word(OP_LOCATE, 7'd0, 32'sd0);
        send_word(OP_INSERT, 7'd0, 32'sd5);
        send_word(OP_INSERT, 7'd2, 32'sd5);
        send_word(OP_CLEAR, 7'd127, -32'sd1);
        wait_for_results();
    endtask

    task automatic test_insert_locate_delete();
        send_word(OP_INSERT, 7'd1, 32'sh7FFF_FFFF);
        send_word(OP_INSERT, 7'd1, 32'sh8000_0000);
        send_word(OP_INSERT, 7'd3, 32'sd0);
        send_word(OP_INSERT, 7'd2, -32'sd1);
        send_word(OP_INSERT, 7'd127, 32'sd9);
        send_word(OP_INSERT, 7'd6, 32'sd9);
        send_word(OP_INSERT, 7'd5, -32'sd1);
        send_word(OP_LOCATE, 7'd0, 32'sh8000_0000);
        send_word(OP_LOCATE, 7'd0, -32'sd1);
        send_word(OP_LOCATE, 7'd0, 32'sh7FFF_FFFE);
        send_word(OP_LOCATE, 7'd127, 32'sd0);
        send_word(OP_DELETE, 7'd0, 32'sd0);
        send_word(OP_DELETE, 7'd6, 32'sd0);
        send_word(OP_DELETE, 7'd3, 32'sd0);
        send_word(OP_DELETE, 7'd4, 32'sd0);
        send_word(OP_DELETE, 7'd1, 32'sd0);
        send_word(OP_CLEAR, 7'd0, 32'sd0);
        send_word(OP_LOCATE, 7'd0, -32'sd1);
        send_word(OP_DELETE, 7'd1, 32'sd0);
        wait_for_results();
    endtask

    task automatic test_full_list();
        while (shadow_count < DEPTH)
            send_word(OP_INSERT, POS_W'($urandom_range(shadow_count + 1, 1)), pick_value());
        send_word(OP_INSERT, 7'd1, 32'sd1);
        send_word(OP_INSERT, 7'd0, 32'sd1);
        send_word(OP_INSERT, 7'd127, 32'sd1);
        send_word(OP_LOCATE, 7'd0, shadow_list[DEPTH-1]);
        send_word(OP_DELETE, 7'd65, 32'sd0);
        send_word(OP_DELETE, POS_W'(DEPTH), 32'sd0);
        send_word(OP_INSERT, POS_W'(DEPTH), 32'sd3);
        send_word(OP_CLEAR, 7'd0, 32'sd0);
        wait_for_results();
    endtask

    // Receiver holds off while the sender keeps offering words.
    task automatic test_output_holdoff();
        int i;
        gaps_on     = 1'b0;
        hold_cycles = HOLD_LONG;
        for (i = 0; i < 12; i++)
            send_word(i % 3 == 0 ? OP_LOCATE : OP_INSERT,
                      POS_W'($urandom_range(shadow_count + 1, 1)), pick_value());
        gaps_on = 1'b1;
        wait_for_results();
    endtask

    task automatic test_random_mix(int n, int ins_pct, int del_pct, int clr_pct);
        int i;
        int r;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < clr_pct)
                send_word(OP_CLEAR, POS_W'($urandom), $urandom);
            else if (r < clr_pct + 7)
            begin
                if ($urandom_range(1, 0))
                    send_word(OP_INSERT, $urandom_range(1, 0) ? 7'd0 :
                              POS_W'($urandom_range(127, shadow_count + 2)), pick_value());
                else
                    send_word(OP_DELETE, $urandom_range(1, 0) ? 7'd0 :
                              POS_W'($urandom_range(127, shadow_count + 1)), $urandom);
            end
            else if (r < clr_pct + 7 + ins_pct)
                send_word(OP_INSERT, POS_W'($urandom_range(shadow_count + 1, 1)),
                          pick_value());
            else if (r < clr_pct + 7 + ins_pct + del_pct)
                send_word(OP_DELETE,
                          POS_W'(shadow_count > 0 ? $urandom_range(shadow_count, 1) : 1),
                          $urandom);
            else if (shadow_count > 0 && $urandom_range(1, 0))
                send_word(OP_LOCATE, POS_W'($urandom),
                          shadow_list[$urandom_range(shadow_count - 1, 0)]);
            else
                send_word(OP_LOCATE, POS_W'($urandom), pick_value());
        end
        wait_for_results();
    endtask

    // Receiver stall pattern: segments of random length and density.
    int stall_mode = 0;
    int seg_left   = 0;
    always @(posedge clk)
    begin
        if (seg_left == 0)
        begin
            stall_mode = $urandom_range(3, 0);
            seg_left   = $urandom_range(200, 20);
        end
        else
            seg_left--;
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
        begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(3, 0) == 0);
                2: out_stall <= ($urandom_range(3, 0) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            result_num++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("UNEXPECTED result %0d: status %0d count %0d",
                             result_num, status, entry_count);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                    report_mismatch({exp_r.op.name(), " status"}, 32'(status),
                                    32'(exp_r.status));
                if (found_position !== exp_r.found)
                    report_mismatch({exp_r.op.name(), " found_position"}, 32'(found_position),
                                    32'(exp_r.found));
                if (removed_value !== exp_r.removed)
                    report_mismatch({exp_r.op.name(), " removed_value"}, removed_value,
                                    exp_r.removed);
                if (entry_count !== exp_r.count)
                    report_mismatch({exp_r.op.name(), " entry_count"}, 32'(entry_count),
                                    32'(exp_r.count));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved in %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_insert_locate_delete();
        test_full_list();
        test_output_holdoff();
        test_random_mix(600, 50, 20, 1);
        test_random_mix(500, 35, 30, 3);
        wait_for_results();
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
rtl/ole_pkg.sv
rtl/ole_cell.sv
rtl/ordered_list_engine.sv
tb/ordered_list_engine_tb.sv
